>>> rtl/obl_pkg.sv
// ----------------------------------------------------------------------------
// obl_pkg: shared types and codes for the ordered byte list
// Holds the command and status codes, the cell operation codes and the
// control bundle that the sequencer broadcasts along the chain of cells.
// ----------------------------------------------------------------------------
package obl_pkg;

  // Command codes carried in the input beat.
  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_FIND       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_e;

  // Status codes reported in every result beat.
  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_EMPTY     = 3'd1,
    STS_RANGE     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FULL      = 3'd4
  } status_e;

  // Operation that every cell applies in the same cycle.
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // Field widths of the stream beats.
  localparam int unsigned CmdW    = 3;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned TotalW  = 5;
  localparam int unsigned MatchW  = 4;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  // Broadcast control for the chain: the operation and the byte it uses.
  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] value;
  } cell_ctrl_t;

endpackage

>>> rtl/obl_cell.sv
// ----------------------------------------------------------------------------
// obl_cell: one storage cell of the ordered byte list
// Holds one byte and its valid flag. On insert it takes the new byte or its
// left neighbor, on erase its right neighbor, and it compares its byte with
// the broadcast value for find.
// ----------------------------------------------------------------------------
module obl_cell #(
  parameter int unsigned PosW    = 4,
  parameter int unsigned CellPos = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  obl_pkg::cell_ctrl_t       ctrl_i,
  input  logic [PosW-1:0]           pos_i,
  input  logic [obl_pkg::ByteW-1:0] left_data_i,
  input  logic                      left_valid_i,
  input  logic [obl_pkg::ByteW-1:0] right_data_i,
  input  logic                      right_valid_i,
  output logic [obl_pkg::ByteW-1:0] data_o,
  output logic                      valid_o,
  output logic                      hit_o,
  output logic [obl_pkg::ByteW-1:0] tail_data_o
);

  localparam logic [PosW-1:0] MyPos = PosW'(CellPos);

  logic [obl_pkg::ByteW-1:0] data_q, data_d;
  logic                      valid_q, valid_d;

  // Next contents of the cell for the broadcast operation.
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      obl_pkg::OP_INSERT: begin
        if (MyPos == pos_i) begin
          data_d  = ctrl_i.value;
          valid_d = 1'b1;
        end else if (MyPos > pos_i) begin
          data_d  = left_data_i;
          valid_d = left_valid_i;
        end
      end
      obl_pkg::OP_ERASE: begin
        if (MyPos >= pos_i) begin
          data_d  = right_data_i;
          valid_d = right_valid_i;
        end
      end
      obl_pkg::OP_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // The valid flag is control state and clears at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // The stored byte is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // The tail cell is the last valid one; it presents its byte as the back.
  assign data_o      = data_q;
  assign valid_o     = valid_q;
  assign hit_o       = valid_q && (data_q == ctrl_i.value);
  assign tail_data_o = (valid_q && !right_valid_i) ? data_q : '0;

endmodule

>>> rtl/obl_chain.sv
// ----------------------------------------------------------------------------
// obl_chain: the row of cells that stores the list
// Wires each cell to its neighbors, gathers the find hits and presents the
// front and back bytes of the list.
// ----------------------------------------------------------------------------
module obl_chain #(
  parameter int unsigned Capacity = 16,
  parameter int unsigned PosW     = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  obl_pkg::cell_ctrl_t       ctrl_i,
  input  logic [PosW-1:0]           pos_i,
  output logic [Capacity-1:0]       hit_o,
  output logic [obl_pkg::ByteW-1:0] front_o,
  output logic [obl_pkg::ByteW-1:0] back_o
);

  logic [obl_pkg::ByteW-1:0] data_w [Capacity];
  logic [obl_pkg::ByteW-1:0] tail_w [Capacity];
  logic [Capacity-1:0]       valid_w;

  // One cell per list position, front at cell zero.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [obl_pkg::ByteW-1:0] left_data, right_data;
    logic                      left_valid, right_valid;

    if (i == 0) begin : g_first
      assign left_data  = '0;
      assign left_valid = 1'b0;
    end else begin : g_inner_left
      assign left_data  = data_w[i-1];
      assign left_valid = valid_w[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_data  = data_w[i+1];
      assign right_valid = valid_w[i+1];
    end

    obl_cell #(
      .PosW    (PosW),
      .CellPos (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .pos_i         (pos_i),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (data_w[i]),
      .valid_o       (valid_w[i]),
      .hit_o         (hit_o[i]),
      .tail_data_o   (tail_w[i])
    );
  end

  // Only one cell is the tail, so the back byte is an OR over all cells.
  always_comb begin
    back_o = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      back_o = back_o | tail_w[i];
    end
  end

  assign front_o = valid_w[0] ? data_w[0] : '0;

endmodule

>>> rtl/ordered_byte_list.sv
// ----------------------------------------------------------------------------
// ordered_byte_list: bounded ordered list of bytes with deque commands
// Top level: decodes commands, steers the chain of cells, scans for find and
// holds the result beat for the output stream.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis stream, one per beat; each command gives
//   exactly one result beat on the m_axis stream, in order.
//   Push, insert, pop, erase and clear update the row of cells at the edge
//   that takes the beat; the result fields are registered there and then
//   loaded into the output register, and a new command is taken in the same
//   cycle that the previous result is loaded, so these run at one beat per
//   cycle while the receiver keeps m_axis_tready high. Find latches the
//   per-cell compare hits and then walks them one cell per cycle from the
//   front toward the back, and reports the first matching position.
//   The one-cell-per-cycle hit walk sets the find time.
//   When the receiver stalls, the result stays in the output register, one
//   more result waits inside, and s_axis_tready drops until space frees.
//   Reset empties the list and the output register; stored bytes are not
//   cleared, they are simply marked invalid.
// ----------------------------------------------------------------------------
module ordered_byte_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command [2:0], index [7:3], value [15:8]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [2:0], front_value [10:3], back_value [18:11],
  // item_total [23:19], match_position [27:24], zero fill [31:28]
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PosW = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CntW > obl_pkg::IndexW) ? CntW : obl_pkg::IndexW;
  localparam int unsigned MPosW = (PosW > obl_pkg::MatchW) ? PosW : obl_pkg::MatchW;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [CntW-1:0]             count_q, count_d;
  logic [obl_pkg::StatusW-1:0] status_q, status_d;
  logic [PosW-1:0]             match_q, match_d;
  logic [CAPACITY-1:0]         vec_q, vec_d;
  logic [PosW-1:0]             scan_q, scan_d;
  logic                        out_valid_q;
  logic [obl_pkg::OutDataW-1:0] out_data_q;

  obl_pkg::cmd_e             cmd;
  logic [obl_pkg::IndexW-1:0] idx;
  logic [obl_pkg::ByteW-1:0] val;
  logic [CmpW-1:0]           idx_ext, cnt_ext;
  logic [CntW-1:0]           cnt_m1;
  logic                      full, empty;
  logic                      in_acc, out_free, load;
  obl_pkg::cell_ctrl_t       ctrl;
  logic [PosW-1:0]           pos;
  logic [CAPACITY-1:0]       hits;
  logic [obl_pkg::ByteW-1:0] front, back;
  logic [MPosW-1:0]          match_ext;

  // Input beat fields.
  assign cmd = obl_pkg::cmd_e'(s_axis_tdata[2:0]);
  assign idx = s_axis_tdata[7:3];
  assign val = s_axis_tdata[15:8];

  assign idx_ext = CmpW'(idx);
  assign cnt_ext = CmpW'(count_q);
  assign cnt_m1  = count_q - CntW'(1);
  assign full    = (count_q == CntW'(CAPACITY));
  assign empty   = (count_q == '0);

  // Handshakes: a result waiting in DONE loads when the output slot frees.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign load          = (state_q == ST_DONE) && out_free;
  assign s_axis_tready = (state_q == ST_IDLE) || load;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Command decode: status, cell operation and new count.
  always_comb begin
    ctrl.op    = obl_pkg::OP_NONE;
    ctrl.value = val;
    pos        = '0;
    count_d    = count_q;
    status_d   = status_q;
    match_d    = match_q;
    vec_d      = vec_q;
    scan_d     = scan_q;
    state_d    = state_q;

    if (load) begin
      state_d = ST_IDLE;
    end

    unique case (state_q)
      ST_SCAN: begin
        // Walk the latched hits from the front toward the back, one position a cycle.
        if (vec_q[0]) begin
          status_d = obl_pkg::STS_OK;
          match_d  = scan_q;
          state_d  = ST_DONE;
        end else if (vec_q == '0) begin
          status_d = obl_pkg::STS_NOT_FOUND;
          match_d  = '0;
          state_d  = ST_DONE;
        end else begin
          vec_d  = vec_q >> 1;
          scan_d = scan_q + PosW'(1);
        end
      end
      default: begin
      end
    endcase

    if (in_acc) begin
      status_d = obl_pkg::STS_OK;
      match_d  = '0;
      state_d  = ST_DONE;
      unique case (cmd)
        obl_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_d = obl_pkg::STS_FULL;
          end else begin
            ctrl.op = obl_pkg::OP_INSERT;
            pos     = count_q[PosW-1:0];
            count_d = count_q + CntW'(1);
          end
        end
        obl_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            status_d = obl_pkg::STS_FULL;
          end else begin
            ctrl.op = obl_pkg::OP_INSERT;
            count_d = count_q + CntW'(1);
          end
        end
        obl_pkg::CMD_INSERT: begin
          if (idx_ext > cnt_ext) begin
            status_d = obl_pkg::STS_RANGE;
          end else if (full) begin
            status_d = obl_pkg::STS_FULL;
          end else begin
            ctrl.op = obl_pkg::OP_INSERT;
            pos     = idx_ext[PosW-1:0];
            count_d = count_q + CntW'(1);
          end
        end
        obl_pkg::CMD_POP_BACK: begin
          if (empty) begin
            status_d = obl_pkg::STS_EMPTY;
          end else begin
            ctrl.op = obl_pkg::OP_ERASE;
            pos     = cnt_m1[PosW-1:0];
            count_d = cnt_m1;
          end
        end
        obl_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            status_d = obl_pkg::STS_EMPTY;
          end else begin
            ctrl.op = obl_pkg::OP_ERASE;
            count_d = cnt_m1;
          end
        end
        obl_pkg::CMD_ERASE: begin
          if (idx_ext >= cnt_ext) begin
            status_d = obl_pkg::STS_RANGE;
          end else begin
            ctrl.op = obl_pkg::OP_ERASE;
            pos     = idx_ext[PosW-1:0];
            count_d = cnt_m1;
          end
        end
        obl_pkg::CMD_FIND: begin
          vec_d   = hits;
          scan_d  = '0;
          state_d = ST_SCAN;
        end
        obl_pkg::CMD_CLEAR: begin
          ctrl.op = obl_pkg::OP_CLEAR;
          count_d = '0;
        end
      endcase
    end
  end

  // Row of cells holding the list.
  obl_chain #(
    .Capacity (CAPACITY),
    .PosW     (PosW)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .pos_i   (pos),
    .hit_o   (hits),
    .front_o (front),
    .back_o  (back)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign match_ext = MPosW'(match_q);

  // Payload registers: pending result fields and the output beat.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    match_q  <= match_d;
    vec_q    <= vec_d;
    scan_q   <= scan_d;
    if (load) begin
      out_data_q <= {4'b0000, match_ext[obl_pkg::MatchW-1:0],
                     cnt_ext[obl_pkg::TotalW-1:0], back, front, status_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
